### rtl/pwq_pkg.sv
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared constants, codes and types of the priority-ordered wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pwq_pkg;

  // queue geometry
  localparam int DEPTH  = 16;
  localparam int ID_W   = 4;
  localparam int PRIO_W = 8;   // at most the width of the priority port
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // port widths fixed by the interface
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int PRIO_IN_W = 8;

  // input function codes
  localparam logic [FUNC_W-1:0] FN_BLOCK      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_WAKE_NAMED = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WAKE_FIRST = 3'd2;
  localparam logic [FUNC_W-1:0] FN_WAKE_ALL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP        = 3'd4;

  // per-cycle operation broadcast to every cell
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SHIFT  = 2'd3;

  // entry presented to every cell
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/pwq_cell.sv
// ----------------------------------------------------------------------------
// pwq_cell
// One slot of the sorted row: holds an id and a priority and takes a new
// entry, its left or right neighbor's data, or keeps its own, each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwq_cell (
  input  wire                      clk,
  input  wire [1:0]                op,
  input  wire pwq_pkg::cell_cmd_t  cmd,
  input  wire                      occ,
  input  wire                      left_goes,
  input  wire [pwq_pkg::ID_W-1:0]  left_id,
  input  wire [pwq_pkg::PRIO_W-1:0] left_prio,
  input  wire [pwq_pkg::ID_W-1:0]  right_id,
  input  wire [pwq_pkg::PRIO_W-1:0] right_prio,
  input  wire                      seen_in,
  output logic                     goes,
  output logic                     seen_out,
  output logic [pwq_pkg::ID_W-1:0] id,
  output logic [pwq_pkg::PRIO_W-1:0] prio
);
  import pwq_pkg::*;

  logic              match;
  logic [ID_W-1:0]   id_next;
  logic [PRIO_W-1:0] prio_next;

  // new entry ranks after this one; matching id found here or to the left
  assign goes     = occ && (prio <= cmd.prio);
  assign match    = occ && (id == cmd.id);
  assign seen_out = seen_in | match;

  // select the next contents
  always_comb begin
    id_next   = id;
    prio_next = prio;
    case (op)
      OP_INSERT: begin
        if (!goes) begin
          if (left_goes) begin
            id_next   = cmd.id;
            prio_next = cmd.prio;
          end else begin
            id_next   = left_id;
            prio_next = left_prio;
          end
        end
      end
      OP_REMOVE: begin
        if (seen_out) begin
          id_next   = right_id;
          prio_next = right_prio;
        end
      end
      OP_SHIFT: begin
        id_next   = right_id;
        prio_next = right_prio;
      end
      default: begin
      end
    endcase
  end

  // slot storage
  always_ff @(posedge clk) begin
    id   <= id_next;
    prio <= prio_next;
  end

endmodule

`default_nettype wire

### rtl/priority_wait_queue.sv
// ----------------------------------------------------------------------------
// priority_wait_queue
// Priority-ordered wait queue of one blocking object, built as a row of
// shifting cells with an occupancy counter and a registered result.
// ----------------------------------------------------------------------------
// Block, wake named, wake first, clear and unknown codes each give a single
// result: the transaction is accepted, the row of cells updates in place at
// that edge and the result sits in the output register from the next cycle.
// A new transaction is taken whenever no wake all is draining and the output
// register is empty or is being drained in the same cycle, so with the
// consumer always ready the block runs one transaction per cycle outside a
// wake all drain. Wake all emits one result per queued id, in rank order,
// one per cycle as the consumer takes them; the row shifts left by one slot
// per result, and the block is busy until every queued id is emitted. The
// critical path is the match prefix chain through all cells for wake named.
`default_nettype none

module priority_wait_queue (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [pwq_pkg::FUNC_W-1:0]        func,
  input  wire [pwq_pkg::ID_W-1:0]          proc_id,
  input  wire [pwq_pkg::PRIO_IN_W-1:0]     priority_req,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [pwq_pkg::ID_W-1:0]         woken_id,
  output logic                             woken_valid,
  output logic [pwq_pkg::STATUS_W-1:0]     status,
  output logic                             last,
  output logic                             queue_empty
);
  import pwq_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic              state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              out_valid_next;
  logic [ID_W-1:0]   woken_id_next;
  logic              woken_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic              last_next;
  logic              queue_empty_next;
  logic              load_out;
  logic              in_fire;
  logic [1:0]        cell_op;
  cell_cmd_t         cmd;

  logic [ID_W-1:0]   cell_id   [DEPTH];
  logic [PRIO_W-1:0] cell_prio [DEPTH];
  logic              cell_goes [DEPTH];
  logic              cell_seen [DEPTH];

  logic any_match;
  logic is_full;
  logic is_empty;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign any_match = cell_seen[DEPTH-1];
  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);

  // entry offered to the row
  assign cmd = '{id: proc_id, prio: priority_req[PRIO_W-1:0]};

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              l_goes;
    logic [ID_W-1:0]   l_id;
    logic [PRIO_W-1:0] l_prio;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic              s_in;

    if (i == 0) begin : g_left_edge
      assign l_goes = 1'b1;
      assign l_id   = '0;
      assign l_prio = '0;
      assign s_in   = 1'b0;
    end else begin : g_left
      assign l_goes = cell_goes[i-1];
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
      assign s_in   = cell_seen[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_edge
      assign r_id   = '0;
      assign r_prio = '0;
    end else begin : g_right
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    pwq_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .cmd        (cmd),
      .occ        (count > CNT_W'(i)),
      .left_goes  (l_goes),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .right_id   (r_id),
      .right_prio (r_prio),
      .seen_in    (s_in),
      .goes       (cell_goes[i]),
      .seen_out   (cell_seen[i]),
      .id         (cell_id[i]),
      .prio       (cell_prio[i])
    );
  end

  // transaction decode and drain sequencing
  always_comb begin
    state_next       = state;
    count_next       = count;
    cell_op          = OP_HOLD;
    load_out         = 1'b0;
    woken_id_next    = '0;
    woken_valid_next = 1'b0;
    status_next      = ST_OK;
    last_next        = 1'b1;
    queue_empty_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (func)
            FN_BLOCK: begin
              if (any_match) begin
                status_next = ST_DUP;
              end else if (is_full) begin
                status_next = ST_FULL;
              end else begin
                cell_op    = OP_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            FN_WAKE_NAMED: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else if (!any_match) begin
                status_next = ST_NOT_QUEUED;
              end else begin
                cell_op          = OP_REMOVE;
                count_next       = count - CNT_W'(1);
                woken_id_next    = proc_id;
                woken_valid_next = 1'b1;
              end
            end
            FN_WAKE_FIRST: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                cell_op          = OP_SHIFT;
                count_next       = count - CNT_W'(1);
                woken_id_next    = cell_id[0];
                woken_valid_next = 1'b1;
              end
            end
            FN_WAKE_ALL: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                cell_op          = OP_SHIFT;
                count_next       = count - CNT_W'(1);
                woken_id_next    = cell_id[0];
                woken_valid_next = 1'b1;
                last_next        = (count == CNT_W'(1));
                if (count != CNT_W'(1)) begin
                  state_next = S_DRAIN;
                end
              end
            end
            FN_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
          queue_empty_next = (count_next == '0);
          // every result of a wake all sees the queue already emptied
          if (func == FN_WAKE_ALL) begin
            queue_empty_next = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (out_ready) begin
          load_out         = 1'b1;
          cell_op          = OP_SHIFT;
          count_next       = count - CNT_W'(1);
          woken_id_next    = cell_id[0];
          woken_valid_next = 1'b1;
          last_next        = (count == CNT_W'(1));
          queue_empty_next = 1'b1;
          if (count == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output valid follows loads and consumer handshakes
  always_comb begin
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      woken_id    <= woken_id_next;
      woken_valid <= woken_valid_next;
      status      <= status_next;
      last        <= last_next;
      queue_empty <= queue_empty_next;
    end
  end

endmodule

`default_nettype wire
